[src/rgbcsc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rgbcsc_pkg
// shared types, constants and step functions of the colour-space converter
// ----------------------------------------------------------------------------
package rgbcsc_pkg;

	localparam int CORDIC_STEPS = 17;
	localparam int CSTAGES      = 9;   // up to two cordic steps per stage
	localparam int DIV_BITS     = 8;
	localparam int XW           = 28;
	localparam int ZW           = 27;
	localparam int SUMW         = 10;
	localparam int REMW         = 18;

	localparam logic [1:0] MODE_PASS   = 2'd0;
	localparam logic [1:0] MODE_CMY    = 2'd1;
	localparam logic [1:0] MODE_HSI    = 2'd2;
	localparam logic [1:0] MODE_HSIMAX = 2'd3;

	localparam logic signed [ZW-1:0] ANG_90  = 27'sd5898240;
	localparam logic signed [ZW-1:0] ANG_180 = 27'sd11796480;
	localparam logic signed [ZW-1:0] ANG_360 = 27'sd23592960;

	typedef logic signed [XW-1:0] vec_t;
	typedef logic signed [ZW-1:0] ang_t;

	typedef struct packed {
		vec_t x;
		vec_t y;
		ang_t z;
	} cordic_t;

	typedef struct packed {
		logic [REMW-1:0] rem;
		logic [7:0]      quo;
		logic [SUMW-1:0] sum;
	} div_t;

	// atan(2^-i) in units of 2^-16 degree
	function automatic ang_t atan_lut(input int i);
		case (i)
			0:  return 27'sd2949120;
			1:  return 27'sd1740967;
			2:  return 27'sd919879;
			3:  return 27'sd466945;
			4:  return 27'sd234379;
			5:  return 27'sd117306;
			6:  return 27'sd58666;
			7:  return 27'sd29335;
			8:  return 27'sd14668;
			9:  return 27'sd7334;
			10: return 27'sd3667;
			11: return 27'sd1833;
			12: return 27'sd917;
			13: return 27'sd458;
			14: return 27'sd229;
			15: return 27'sd115;
			16: return 27'sd57;
			default: return '0;
		endcase
	endfunction

	// arithmetic shift rounding toward zero
	function automatic vec_t shift_tz(input vec_t v, input int s);
		logic [XW-1:0] m;
		m = v[XW-1] ? XW'(-v) : XW'(v);
		m = m >> s;
		return v[XW-1] ? -vec_t'(m) : vec_t'(m);
	endfunction

	function automatic cordic_t cordic_step(input cordic_t c, input int i);
		cordic_t r;
		r = c;
		if (!c.y[XW-1]) begin
			r.x = c.x + shift_tz(c.y, i);
			r.y = c.y - shift_tz(c.x, i);
			r.z = c.z + atan_lut(i);
		end else begin
			r.x = c.x - shift_tz(c.y, i);
			r.y = c.y + shift_tz(c.x, i);
			r.z = c.z - atan_lut(i);
		end
		return r;
	endfunction

	// one restoring division step for quotient bit k
	function automatic div_t div_step(input div_t d, input int k);
		div_t            r;
		logic [REMW-1:0] dv;
		r  = d;
		dv = REMW'(d.sum) << k;
		if (d.rem >= dv) begin
			r.rem    = d.rem - dv;
			r.quo[k] = 1'b1;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

[src/rgbcsc_cordic.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rgbcsc_cordic
// pipelined vectoring cordic giving the hue angle, up to two steps per stage
// ----------------------------------------------------------------------------
module rgbcsc_cordic import rgbcsc_pkg::*; (
	input  wire logic    clk,
	input  wire logic    en,
	input  wire cordic_t start,
	input  wire logic    grey_in,
	input  wire logic    dneg_in,
	output ang_t         angle,
	output logic         grey,
	output logic         dneg
);

	cordic_t stage_s [CSTAGES];
	logic    grey_s  [CSTAGES];
	logic    dneg_s  [CSTAGES];

	genvar k;
	for (k = 0; k < CSTAGES; k++) begin : g_stage
		cordic_t prev;
		cordic_t nxt;
		logic    gprev;
		logic    dprev;
		if (k == 0) begin : g_first
			assign prev  = start;
			assign gprev = grey_in;
			assign dprev = dneg_in;
		end else begin : g_rest
			assign prev  = stage_s[k-1];
			assign gprev = grey_s[k-1];
			assign dprev = dneg_s[k-1];
		end
		always_comb begin
			nxt = cordic_step(prev, 2*k);
			if (2*k+1 < CORDIC_STEPS)
				nxt = cordic_step(nxt, 2*k+1);
		end
		always_ff @(posedge clk) begin
			if (en) begin
				stage_s[k] <= nxt;
				grey_s[k]  <= gprev;
				dneg_s[k]  <= dprev;
			end
		end
	end

	assign angle = stage_s[CSTAGES-1].z;
	assign grey  = grey_s[CSTAGES-1];
	assign dneg  = dneg_s[CSTAGES-1];

endmodule
`default_nettype wire

[src/rgbcsc_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rgbcsc_div
// pipelined restoring divider for the saturation, one quotient bit per stage but the spare ones
// ----------------------------------------------------------------------------
module rgbcsc_div import rgbcsc_pkg::*; (
	input  wire logic       clk,
	input  wire logic       en,
	input  wire div_t       start,
	output logic [7:0]      quo
);

	div_t stage_s [CSTAGES];

	genvar k;
	for (k = 0; k < CSTAGES; k++) begin : g_stage
		div_t prev;
		div_t nxt;
		if (k == 0) begin : g_first
			assign prev = start;
		end else begin : g_rest
			assign prev = stage_s[k-1];
		end
		// spare stages only carry the result to match the cordic depth
		always_comb begin
			nxt = prev;
			if (k < DIV_BITS)
				nxt = div_step(prev, DIV_BITS-1-k);
		end
		always_ff @(posedge clk) begin
			if (en)
				stage_s[k] <= nxt;
		end
	end

	assign quo = stage_s[CSTAGES-1].quo;

endmodule
`default_nettype wire

[src/rgbcsc_hue_scale.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rgbcsc_hue_scale
// clamps and mirrors the angle and scales it to 0..255 over three stages
// ----------------------------------------------------------------------------
module rgbcsc_hue_scale import rgbcsc_pkg::*; (
	input  wire logic       clk,
	input  wire logic       en,
	input  wire ang_t       angle,
	input  wire logic       grey,
	input  wire logic       dneg,
	output logic [7:0]      hue
);

	ang_t        zc;
	logic [32:0] p1;
	logic [16:0] t_s1;
	logic [27:0] p2;
	logic [27:0] p2_s2;
	logic [8:0]  q;
	logic [7:0]  hue_s3;

	always_comb begin
		zc = angle;
		if (grey)
			zc = '0;
		else if (zc < 0)
			zc = '0;
		else if (zc > ANG_180)
			zc = ANG_180;
		if (dneg)
			zc = ANG_360 - zc;
		p1 = 33'(zc[24:0]) * 33'd255;
	end

	// divide by 360 * 2^16: shift by 19, then times the reciprocal of 45
	assign p2 = 28'(t_s1[16:3]) * 28'd11651;
	assign q  = p2_s2[27:19];

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1   <= p1[32:16];
			p2_s2  <= p2;
			hue_s3 <= q[8] ? 8'hFF : q[7:0];
		end
	end

	assign hue = hue_s3;

endmodule
`default_nettype wire

[src/rgb_pixel_color_space_converter.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_pixel_color_space_converter
// bgr pixel to pass-through, cmy or hsi channels, while not stalled one pixel per clock
// ----------------------------------------------------------------------------
//  channel  signals                                   direction
//  pixel    in_valid, in_stall, pixel_blue/green/red  in
//  result   out_valid, out_stall, out_first/second/   out
//           out_third
//  config   cfg_valid, cfg_ready, cfg_data (mode)     in
//
// one transaction per clock unless the result side stalls; each pixel passes
// from input to output register via front, nine cordic and scaling stages
// arst_n clears the valid chain and the mode register (pass through)
// a stall on the result side with a result waiting freezes the whole pipeline
// and raises in_stall; nothing is dropped or repeated
// ----------------------------------------------------------------------------
module rgb_pixel_color_space_converter import rgbcsc_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] pixel_blue,
	input  wire logic [7:0] pixel_green,
	input  wire logic [7:0] pixel_red,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      out_first,
	output logic [7:0]      out_second,
	output logic [7:0]      out_third,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [1:0] cfg_data
);

	localparam int LAT     = 13;
	localparam int DIV_IDX = CSTAGES + 1;   // stage at which the quotient joins

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] first;
		logic [7:0] second;
		logic [7:0] third;
	} side_t;

	logic [1:0] mode_q;
	logic       en;
	logic       v_s    [LAT];
	side_t      side_s [LAT];

	// front stage signals
	logic [SUMW-1:0]   sum;
	logic [7:0]        mn, mx, dabs;
	logic signed [10:0] xr;
	vec_t              x_raw, y_raw;
	cordic_t           c_in, c_s1;
	logic              grey_in, dneg_in, grey_s1, dneg_s1;
	logic [SUMW-1:0]   sm;
	logic [19:0]       third_prod;
	div_t              d_in, d_s1;
	side_t             side_in;
	logic              hsi_in, hsi_out;

	// side channel entry that takes the saturation quotient
	side_t      side_div;

	// black pixel flag travelling beside the divider
	logic       zero_s [CSTAGES];
	logic       d_sum_zero_q9;

	// cordic, divider and scaler outputs
	ang_t       angle;
	logic       c_grey, c_dneg;
	logic [7:0] sat_quo;
	logic [7:0] hue;

	// the whole pipeline moves unless a finished result is held back
	assign en        = !(v_s[LAT-1] && out_stall);
	assign in_stall  = !en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_PASS;
		end else if (cfg_valid) begin
			mode_q <= cfg_data;
		end
	end

	// channel statistics, cordic start vector, divider input and side channel entry
	always_comb begin
		sum     = SUMW'(pixel_red) + SUMW'(pixel_green) + SUMW'(pixel_blue);
		mn      = (pixel_red < pixel_green) ? pixel_red : pixel_green;
		mn      = (mn < pixel_blue) ? mn : pixel_blue;
		mx      = (pixel_red > pixel_green) ? pixel_red : pixel_green;
		mx      = (mx > pixel_blue) ? mx : pixel_blue;
		dneg_in = pixel_green < pixel_blue;
		dabs    = dneg_in ? (pixel_blue - pixel_green) : (pixel_green - pixel_blue);
		grey_in = (pixel_red == pixel_green) && (pixel_green == pixel_blue);
		xr      = $signed({2'b00, pixel_red, 1'b0}) - $signed({3'b000, pixel_green})
		          - $signed({3'b000, pixel_blue});
		x_raw   = vec_t'(xr) <<< 16;
		y_raw   = vec_t'(28'(dabs) * 28'd113512);
		// left half-plane: rotate by 90 degrees first
		if (x_raw < 0) begin
			c_in.x = y_raw;
			c_in.y = -x_raw;
			c_in.z = ANG_90;
		end else begin
			c_in.x = x_raw;
			c_in.y = y_raw;
			c_in.z = '0;
		end
		// saturation numerator 255 * (sum - 3 * min)
		sm        = sum - SUMW'(3 * mn);
		d_in.rem  = REMW'(sm) * REMW'(255);
		d_in.quo  = '0;
		d_in.sum  = sum;
		// sum / 3 by reciprocal
		third_prod = 20'(sum) * 20'd683;
		side_in.mode = mode_q;
		case (mode_q)
			MODE_PASS: begin
				side_in.first  = pixel_blue;
				side_in.second = pixel_green;
				side_in.third  = pixel_red;
			end
			MODE_CMY: begin
				side_in.first  = 8'hFF - pixel_blue;
				side_in.second = 8'hFF - pixel_green;
				side_in.third  = 8'hFF - pixel_red;
			end
			MODE_HSI: begin
				side_in.first  = '0;
				side_in.second = '0;
				side_in.third  = third_prod[18:11];
			end
			default: begin
				side_in.first  = '0;
				side_in.second = '0;
				side_in.third  = mx;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LAT; i++)
				v_s[i] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
			for (int i = 1; i < LAT; i++)
				v_s[i] <= v_s[i-1];
		end
	end

	// saturation quotient joins the side channel
	always_comb begin
		side_div = side_s[DIV_IDX-1];
		if (hsi_in)
			side_div.second = d_sum_zero_q9 ? 8'd0 : sat_quo;
	end

	// payload of the front stage and the side channel
	always_ff @(posedge clk) begin
		if (en) begin
			c_s1      <= c_in;
			grey_s1   <= grey_in;
			dneg_s1   <= dneg_in;
			d_s1      <= d_in;
			side_s[0] <= side_in;
			for (int i = 1; i < LAT; i++)
				side_s[i] <= (i == DIV_IDX) ? side_div : side_s[i-1];
		end
	end

	assign hsi_in = (side_s[DIV_IDX-1].mode == MODE_HSI)
	             || (side_s[DIV_IDX-1].mode == MODE_HSIMAX);

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= (d_s1.sum == '0);
			for (int i = 1; i < CSTAGES; i++)
				zero_s[i] <= zero_s[i-1];
		end
	end
	assign d_sum_zero_q9 = zero_s[CSTAGES-1];

	rgbcsc_cordic u_cordic (
		.clk     (clk),
		.en      (en),
		.start   (c_s1),
		.grey_in (grey_s1),
		.dneg_in (dneg_s1),
		.angle   (angle),
		.grey    (c_grey),
		.dneg    (c_dneg)
	);

	rgbcsc_div u_div (
		.clk   (clk),
		.en    (en),
		.start (d_s1),
		.quo   (sat_quo)
	);

	rgbcsc_hue_scale u_hue (
		.clk   (clk),
		.en    (en),
		.angle (angle),
		.grey  (c_grey),
		.dneg  (c_dneg),
		.hue   (hue)
	);

	assign hsi_out    = (side_s[LAT-1].mode == MODE_HSI)
	                 || (side_s[LAT-1].mode == MODE_HSIMAX);
	assign out_valid  = v_s[LAT-1];
	assign out_first  = hsi_out ? hue : side_s[LAT-1].first;
	assign out_second = side_s[LAT-1].second;
	assign out_third  = side_s[LAT-1].third;

endmodule
`default_nettype wire

[dv/hsi_result_checker.sv]
// ----------------------------------------------------------------------------
// hsi_result_checker
// watches the pixel, result and mode channels of the colour-space converter,
// predicts each result and compares it field by field in order of arrival
// ----------------------------------------------------------------------------
module hsi_result_checker import rgbcsc_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic       in_stall,
	input  wire logic [7:0] pixel_blue,
	input  wire logic [7:0] pixel_green,
	input  wire logic [7:0] pixel_red,
	input  wire logic       out_valid,
	input  wire logic       out_stall,
	input  wire logic [7:0] out_first,
	input  wire logic [7:0] out_second,
	input  wire logic [7:0] out_third,
	input  wire logic       cfg_valid,
	input  wire logic       cfg_ready,
	input  wire logic [1:0] cfg_data,
	output int              fail_count,
	output int              pending_count
);

	typedef struct {
		logic [7:0] first;
		logic [7:0] second;
		logic [7:0] third;
	} channels_t;

	channels_t  expected_channels[$];
	logic [1:0] mode_now;

	assign pending_count = expected_channels.size();

	function automatic longint shift_to_zero(longint v, int s);
		if (v < 0)
			return -((-v) >>> s);
		return v >>> s;
	endfunction

	// hue angle in 2^-16 degree
	function automatic longint hue_of(longint r, longint g, longint b);
		longint atan_q16[17] = '{2949120, 1740967, 919879, 466945, 234379, 117306,
			58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57};
		longint d, x, y, z, t;
		d = g - b;
		x = (2 * r - g - b) * 65536;
		y = (d < 0 ? -d : d) * 113512;
		z = 0;
		if (r == g && g == b)
			return 0;
		if (x < 0) begin
			t = x;
			x = y;
			y = -t;
			z = 90 * 65536;
		end
		for (int i = 0; i < 17; i++) begin
			t = x;
			if (y >= 0) begin
				x += shift_to_zero(y, i);
				y -= shift_to_zero(t, i);
				z += atan_q16[i];
			end else begin
				x -= shift_to_zero(y, i);
				y += shift_to_zero(t, i);
				z -= atan_q16[i];
			end
		end
		if (z < 0) z = 0;
		if (z > 180 * 65536) z = 180 * 65536;
		if (d < 0) z = 360 * 65536 - z;
		return z;
	endfunction

	function automatic channels_t convert_pixel(logic [1:0] m, logic [7:0] b8,
		logic [7:0] g8, logic [7:0] r8);
		channels_t c;
		longint    b, g, r, sum, mn, mx, h;
		b = b8;
		g = g8;
		r = r8;
		case (m)
			MODE_PASS: begin
				c.first = b8; c.second = g8; c.third = r8;
			end
			MODE_CMY: begin
				c.first = ~b8; c.second = ~g8; c.third = ~r8;
			end
			default: begin
				sum = r + g + b;
				mn = r < g ? r : g;
				mn = mn < b ? mn : b;
				mx = r > g ? r : g;
				mx = mx > b ? mx : b;
				h = hue_of(r, g, b) * 255 / (360 * 65536);
				if (h > 255) h = 255;
				c.first = h[7:0];
				c.second = sum == 0 ? 8'd0 : 8'((255 * (sum - 3 * mn)) / sum);
				c.third = m == MODE_HSI ? 8'(sum / 3) : mx[7:0];
			end
		endcase
		return c;
	endfunction

	task automatic report_mismatch(string what);
		$display("%0t checker: %s", $time, what);
		fail_count++;
	endtask

	initial fail_count = 0;

	always @(posedge clk or negedge arst_n) begin
		channels_t e;
		if (!arst_n) begin
			mode_now <= MODE_PASS;
		end else begin
			if (cfg_valid && cfg_ready)
				mode_now <= cfg_data;
			if (in_valid && !in_stall)
				expected_channels.push_back(convert_pixel(mode_now, pixel_blue,
					pixel_green, pixel_red));
			if (out_valid && !out_stall) begin
				if (expected_channels.size() == 0) begin
					report_mismatch("result transaction with nothing expected");
				end else begin
					e = expected_channels.pop_front();
					if (out_first !== e.first)
						report_mismatch($sformatf("first %0d exp %0d", out_first, e.first));
					if (out_second !== e.second)
						report_mismatch($sformatf("second %0d exp %0d", out_second, e.second));
					if (out_third !== e.third)
						report_mismatch($sformatf("third %0d exp %0d", out_third, e.third));
				end
			end
		end
	end

endmodule

[dv/tb_rgb_pixel_color_space_converter.sv]
// ----------------------------------------------------------------------------
// tb_rgb_pixel_color_space_converter
// drives pixels through every mode with random idling and a long result
// hold-off; the checker predicts and compares, this top gives the verdict
// ----------------------------------------------------------------------------
module tb_rgb_pixel_color_space_converter import rgbcsc_pkg::*;;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] pixel_blue;
	logic [7:0] pixel_green;
	logic [7:0] pixel_red;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] out_first;
	logic [7:0] out_second;
	logic [7:0] out_third;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [1:0] cfg_data;
	int         fail_count;
	int         pending_count;

	// result side behaviour, set by the stimulus process
	bit         calm_phase;
	int         hold_cycles;

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	rgb_pixel_color_space_converter dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.pixel_blue(pixel_blue), .pixel_green(pixel_green), .pixel_red(pixel_red),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_first(out_first), .out_second(out_second), .out_third(out_third),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	hsi_result_checker checker_inst (.*);

	// result side: random stalls, a long hold-off on request
	initial begin
		out_stall = 1'b1;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !calm_phase && ($urandom_range(99) < 13);
			end
		end
	end

	// offer one pixel and wait for its transaction
	task automatic send_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r);
		if (!calm_phase)
			while ($urandom_range(99) < 13) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		in_valid    <= 1'b1;
		pixel_blue  <= b;
		pixel_green <= g;
		pixel_red   <= r;
		do @(posedge clk); while (in_stall);
	endtask

	// mode written only while the pipeline is empty
	task automatic write_mode(logic [1:0] m);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= m;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_pixel();
		case ($urandom_range(5))
			0: begin
				// grey
				logic [7:0] v;
				v = 8'($urandom);
				send_pixel(v, v, v);
			end
			1: send_pixel(8'($urandom_range(1) * 255), 8'($urandom_range(1) * 255),
				8'($urandom_range(1) * 255));
			default: send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
		endcase
	endtask

	initial begin
		logic [1:0] mode_order[6] = '{MODE_PASS, MODE_CMY, MODE_HSI, MODE_HSIMAX,
			MODE_HSI, MODE_PASS};
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		pixel_blue  = '0;
		pixel_green = '0;
		pixel_red   = '0;
		cfg_valid   = 1'b0;
		cfg_data    = MODE_PASS;
		calm_phase  = 1'b0;
		hold_cycles = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, grey, black, hue sectors, in each mode
		foreach (mode_order[k]) begin
			if (k < 4) begin
				write_mode(mode_order[k]);
				send_pixel(8'd0, 8'd0, 8'd0);
				send_pixel(8'd255, 8'd255, 8'd255);
				send_pixel(8'd77, 8'd77, 8'd77);
				send_pixel(8'd0, 8'd0, 8'd255);
				send_pixel(8'd0, 8'd255, 8'd0);
				send_pixel(8'd255, 8'd0, 8'd0);
				send_pixel(8'd255, 8'd0, 8'd255);
				send_pixel(8'd1, 8'd0, 8'd0);
			end
		end

		// random: mode phases, one with no idling, one with a long hold-off
		foreach (mode_order[k]) begin
			write_mode(mode_order[k]);
			calm_phase = (k == 2);
			if (k == 3)
				hold_cycles = 200;
			repeat (135) random_pixel();
		end
		calm_phase = 1'b0;
		in_valid <= 1'b0;

		while (pending_count != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#400000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

[rgb_pixel_color_space_converter.f]
src/rgbcsc_pkg.sv
src/rgbcsc_cordic.sv
src/rgbcsc_div.sv
src/rgbcsc_hue_scale.sv
src/rgb_pixel_color_space_converter.sv
dv/hsi_result_checker.sv
dv/tb_rgb_pixel_color_space_converter.sv
